// ----- design/qlsf_pkg.sv -----
// Package for the quadratic least-squares fit core: widths, codes, sequencer states
// and the saturating fixed-point helpers shared by the datapath and the arithmetic units.
// No dependencies.
package qlsf_pkg;

   localparam int MAX_POINTS = 32;
   localparam int FRAC_BITS  = 24;
   localparam int COUNT_W    = 9;
   localparam int MIN_W      = 6;
   localparam int IN_W       = 32;
   localparam int WORD_W     = 64;
   localparam int COEF_W     = 48;

   localparam logic [MIN_W-1:0]  MIN_RESET = 6'd5;
   localparam logic [WORD_W-1:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
   localparam logic [WORD_W-1:0] WORD_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [WORD_W-1:0] COEF_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [WORD_W-1:0] COEF_MIN = 64'shFFFF_8000_0000_0000;

   typedef struct packed {
      logic signed [WORD_W-1:0] value;
      logic                     sat;
   } arith_type;

   typedef struct packed {
      logic                     start;
      logic signed [WORD_W-1:0] a;
      logic signed [WORD_W-1:0] b;
   } unit_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [WORD_W-1:0] value;
      logic                     sat;
   } unit_rsp_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FEW   = 2'd1,
      STATUS_PIVOT = 2'd2,
      STATUS_SAT   = 2'd3
   } fit_status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ACC_ADD,
      ST_ACC_MUL,
      ST_ACC_WAIT,
      ST_FIT_CHECK,
      ST_LOAD,
      ST_PIV_RD,
      ST_PIV_CMP,
      ST_ZCHK_RD,
      ST_ZCHK,
      ST_ELIM_RD,
      ST_ELIM_DIV,
      ST_ELIM_DIV_WAIT,
      ST_ELIM_MRD,
      ST_ELIM_MUL,
      ST_ELIM_MUL_WAIT,
      ST_BACK_RD,
      ST_BACK_ACC,
      ST_BACK_MRD,
      ST_BACK_MUL,
      ST_BACK_MUL_WAIT,
      ST_BACK_DRD,
      ST_BACK_DCHK,
      ST_BACK_DIV_WAIT,
      ST_FINISH,
      ST_OUT
   } state_type;

   function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] m;
      m = v[WORD_W-1] ? (~v + 64'd1) : v;
      return m;
   endfunction

   function automatic arith_type sign_apply(input logic neg, input logic [WORD_W-1:0] m,
                                            input logic over);
      arith_type r;
      if (neg) begin
         if (over || (m > SIGN_BIT)) begin
            r.value = SIGN_BIT;
            r.sat   = 1'b1;
         end else begin
            r.value = ~m + 64'd1;
            r.sat   = 1'b0;
         end
      end else if (over || m[WORD_W-1]) begin
         r.value = WORD_MAX;
         r.sat   = 1'b1;
      end else begin
         r.value = m;
         r.sat   = 1'b0;
      end
      return r;
   endfunction

   function automatic arith_type sat_add(input logic [WORD_W-1:0] a,
                                         input logic [WORD_W-1:0] b);
      arith_type         r;
      logic [WORD_W-1:0] s;
      s = a + b;
      if ((a[WORD_W-1] == b[WORD_W-1]) && (s[WORD_W-1] != a[WORD_W-1])) begin
         r.value = a[WORD_W-1] ? SIGN_BIT : WORD_MAX;
         r.sat   = 1'b1;
      end else begin
         r.value = s;
         r.sat   = 1'b0;
      end
      return r;
   endfunction

   function automatic arith_type sat_sub(input logic [WORD_W-1:0] a,
                                         input logic [WORD_W-1:0] b);
      arith_type         r;
      logic [WORD_W-1:0] s;
      s = a - b;
      if ((a[WORD_W-1] != b[WORD_W-1]) && (s[WORD_W-1] != a[WORD_W-1])) begin
         r.value = a[WORD_W-1] ? SIGN_BIT : WORD_MAX;
         r.sat   = 1'b1;
      end else begin
         r.value = s;
         r.sat   = 1'b0;
      end
      return r;
   endfunction

endpackage

// ----- design/qlsf_if.sv -----
// Valid/ready channel interfaces for the fit core: point input, result output and
// the configuration write port. Depends on qlsf_pkg.
interface qlsf_req_if import qlsf_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [IN_W-1:0] x_value;
   logic signed [IN_W-1:0] y_value;
   logic                   last_point;

   modport source (output valid, x_value, y_value, last_point, input ready);
   modport sink (input valid, x_value, y_value, last_point, output ready);
endinterface

interface qlsf_rsp_if import qlsf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [COEF_W-1:0] coeff_const;
   logic signed [COEF_W-1:0] coeff_linear;
   logic signed [COEF_W-1:0] coeff_square;
   logic [1:0]               fit_status;

   modport source (output valid, coeff_const, coeff_linear, coeff_square, fit_status,
                   input ready);
   modport sink (input valid, coeff_const, coeff_linear, coeff_square, fit_status,
                 output ready);
endinterface

interface qlsf_csr_if import qlsf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [MIN_W-1:0] min_points;

   modport source (output valid, min_points, input ready);
   modport sink (input valid, min_points, output ready);
endinterface

// ----- design/quadratic_least_squares_fit_core.sv -----
// Each point runs five products through the shared multiplier; no new point is taken meanwhile.
// A point marked last starts a fit of six divisions and eleven multiplications in the
// elimination and back-substitution sequence; too few points or a zero pivot end it early.
// The result beat then waits in an output register; no point is taken until it is taken.
// Reset is synchronous; sums clear at once, the matrix needs no clear.
// Depends on qlsf_pkg, qlsf_if, qlsf_mul and qlsf_div.
module quadratic_least_squares_fit_core import qlsf_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   qlsf_req_if.sink   req_bus,
   qlsf_rsp_if.source rsp_bus,
   qlsf_csr_if.sink   csr_bus
);

   state_type state_ff, state_in;

   logic signed [IN_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic                     last_ff, last_in;
   logic signed [WORD_W-1:0] x2_ff, x2_in, term_ff, term_in, opnd_ff, opnd_in;
   logic signed [WORD_W-1:0] ps_ff [4];
   logic signed [WORD_W-1:0] ps_in [4];
   logic signed [WORD_W-1:0] ms_ff [3];
   logic signed [WORD_W-1:0] ms_in [3];
   logic signed [WORD_W-1:0] coef_ff [3];
   logic signed [WORD_W-1:0] coef_in [3];
   logic [1:0]               perm_ff [3];
   logic [1:0]               perm_in [3];
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic                     sat_ff, sat_in, fsat_ff, fsat_in;
   fit_status_type           status_ff, status_in;
   logic [1:0]               i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [2:0]               step_ff, step_in;
   logic [MIN_W-1:0]         min_ff;
   logic [WORD_W-1:0]        rd_a_ff, rd_b_ff;
   logic [WORD_W-1:0]        mat_mem [12];

   logic [3:0]               addr_a, addr_b, wr_addr;
   logic                     wr_en;
   logic [WORD_W-1:0]        wr_data;
   unit_req_type             mul_req, div_req;
   unit_rsp_type             mul_rsp, div_rsp;

   logic signed [WORD_W-1:0] x_wide, y_wide, acc_target, pw_sel;
   arith_type                add_x, add_y, add_acc, sub_res;
   logic [1:0]               prow_i, prow_k;
   logic [2:0]               pw_idx;
   logic                     req_fire, few_points, swap_rows;

   qlsf_mul u_mul (.clock(clock), .reset(reset), .req(mul_req), .rsp(mul_rsp));
   qlsf_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   assign req_fire   = req_bus.valid && req_bus.ready;
   assign few_points = count_ff < {3'd0, min_ff};
   assign x_wide     = {{(WORD_W-IN_W){x_ff[IN_W-1]}}, x_ff};
   assign y_wide     = {{(WORD_W-IN_W){y_ff[IN_W-1]}}, y_ff};
   assign prow_i     = perm_ff[i_ff];
   assign prow_k     = perm_ff[k_ff];
   assign swap_rows  = magnitude(rd_a_ff) > magnitude(rd_b_ff);
   assign pw_idx     = {1'b0, i_ff} + {1'b0, j_ff};

   always_comb begin
      case (step_ff)
         3'd0:    acc_target = ps_ff[1];
         3'd1:    acc_target = ps_ff[2];
         3'd2:    acc_target = ps_ff[3];
         3'd3:    acc_target = ms_ff[1];
         default: acc_target = ms_ff[2];
      endcase
      case (pw_idx)
         3'd0:    pw_sel = WORD_W'({55'd0, count_ff}) << FRAC_BITS;
         3'd1:    pw_sel = ps_ff[0];
         3'd2:    pw_sel = ps_ff[1];
         3'd3:    pw_sel = ps_ff[2];
         default: pw_sel = ps_ff[3];
      endcase
      add_x   = sat_add(ps_ff[0], x_wide);
      add_y   = sat_add(ms_ff[0], y_wide);
      add_acc = sat_add(acc_target, mul_rsp.value);
      sub_res = sat_sub(opnd_ff, mul_rsp.value);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (count_ff < COUNT_W'(MAX_POINTS)) begin
                  state_in = ST_ACC_ADD;
               end else if (req_bus.last_point) begin
                  state_in = ST_FIT_CHECK;
               end
            end
         end
         ST_ACC_ADD: state_in = ST_ACC_MUL;
         ST_ACC_MUL: state_in = ST_ACC_WAIT;
         ST_ACC_WAIT: begin
            if (mul_rsp.done) begin
               if (step_ff == 3'd4) begin
                  state_in = last_ff ? ST_FIT_CHECK : ST_IDLE;
               end else begin
                  state_in = ST_ACC_MUL;
               end
            end
         end
         ST_FIT_CHECK: state_in = few_points ? ST_OUT : ST_LOAD;
         ST_LOAD: begin
            if ((i_ff == 2'd2) && (j_ff == 2'd3)) begin
               state_in = ST_PIV_RD;
            end
         end
         ST_PIV_RD: state_in = ST_PIV_CMP;
         ST_PIV_CMP: state_in = (k_ff == 2'd2) ? ST_ZCHK_RD : ST_PIV_RD;
         ST_ZCHK_RD: state_in = ST_ZCHK;
         ST_ZCHK: state_in = (rd_a_ff == '0) ? ST_OUT : ST_ELIM_RD;
         ST_ELIM_RD: state_in = ST_ELIM_DIV;
         ST_ELIM_DIV: state_in = ST_ELIM_DIV_WAIT;
         ST_ELIM_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_ELIM_MRD;
            end
         end
         ST_ELIM_MRD: state_in = ST_ELIM_MUL;
         ST_ELIM_MUL: state_in = ST_ELIM_MUL_WAIT;
         ST_ELIM_MUL_WAIT: begin
            if (mul_rsp.done) begin
               if (j_ff != 2'd3) begin
                  state_in = ST_ELIM_MRD;
               end else if (k_ff != 2'd2) begin
                  state_in = ST_ELIM_RD;
               end else begin
                  state_in = (i_ff == 2'd1) ? ST_BACK_RD : ST_PIV_RD;
               end
            end
         end
         ST_BACK_RD: state_in = ST_BACK_ACC;
         ST_BACK_ACC: state_in = (j_ff == 2'd3) ? ST_BACK_DRD : ST_BACK_MRD;
         ST_BACK_MRD: state_in = ST_BACK_MUL;
         ST_BACK_MUL: state_in = ST_BACK_MUL_WAIT;
         ST_BACK_MUL_WAIT: begin
            if (mul_rsp.done) begin
               state_in = (j_ff == 2'd2) ? ST_BACK_DRD : ST_BACK_MRD;
            end
         end
         ST_BACK_DRD: state_in = ST_BACK_DCHK;
         ST_BACK_DCHK: state_in = (rd_a_ff == '0) ? ST_OUT : ST_BACK_DIV_WAIT;
         ST_BACK_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = (i_ff == 2'd0) ? ST_FINISH : ST_BACK_RD;
            end
         end
         ST_FINISH: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = (state_ff == ST_IDLE);
      rsp_bus.valid = (state_ff == ST_OUT);
      mul_req       = '0;
      div_req       = '0;
      addr_a        = 4'd0;
      addr_b        = 4'd0;
      wr_en         = 1'b0;
      wr_addr       = {prow_k, j_ff};
      case (state_ff)
         ST_ACC_MUL: begin
            mul_req.start = 1'b1;
            case (step_ff)
               3'd0: begin
                  mul_req.a = x_wide;
                  mul_req.b = x_wide;
               end
               3'd1: begin
                  mul_req.a = x2_ff;
                  mul_req.b = x_wide;
               end
               3'd2: begin
                  mul_req.a = x2_ff;
                  mul_req.b = x2_ff;
               end
               3'd3: begin
                  mul_req.a = x_wide;
                  mul_req.b = y_wide;
               end
               default: begin
                  mul_req.a = x2_ff;
                  mul_req.b = y_wide;
               end
            endcase
         end
         ST_LOAD: begin
            wr_en   = 1'b1;
            wr_addr = {i_ff, j_ff};
         end
         ST_PIV_RD, ST_ELIM_RD: begin
            addr_a = {prow_k, i_ff};
            addr_b = {prow_i, i_ff};
         end
         ST_ZCHK_RD, ST_BACK_DRD: addr_a = {prow_i, i_ff};
         ST_ELIM_DIV: begin
            div_req.start = 1'b1;
            div_req.a     = rd_a_ff;
            div_req.b     = rd_b_ff;
         end
         ST_ELIM_MRD: begin
            addr_a = {prow_i, j_ff};
            addr_b = {prow_k, j_ff};
         end
         ST_ELIM_MUL: begin
            mul_req.start = 1'b1;
            mul_req.a     = term_ff;
            mul_req.b     = rd_a_ff;
         end
         ST_ELIM_MUL_WAIT: wr_en = mul_rsp.done;
         ST_BACK_RD: addr_a = {prow_i, 2'd3};
         ST_BACK_MRD: addr_a = {prow_i, j_ff};
         ST_BACK_MUL: begin
            mul_req.start = 1'b1;
            mul_req.a     = rd_a_ff;
            mul_req.b     = coef_ff[j_ff];
         end
         ST_BACK_DCHK: begin
            div_req.start = (rd_a_ff != '0);
            div_req.a     = opnd_ff;
            div_req.b     = rd_a_ff;
         end
         default: begin
         end
      endcase
      wr_data = (state_ff == ST_LOAD) ? ((j_ff == 2'd3) ? ms_ff[i_ff] : pw_sel)
                                      : sub_res.value;
   end

   always_comb begin
      x_in      = x_ff;
      y_in      = y_ff;
      last_in   = last_ff;
      x2_in     = x2_ff;
      term_in   = term_ff;
      opnd_in   = opnd_ff;
      ps_in     = ps_ff;
      ms_in     = ms_ff;
      coef_in   = coef_ff;
      perm_in   = perm_ff;
      count_in  = count_ff;
      sat_in    = sat_ff;
      fsat_in   = fsat_ff;
      status_in = status_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      step_in   = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               x_in    = req_bus.x_value;
               y_in    = req_bus.y_value;
               last_in = req_bus.last_point;
            end
         end
         ST_ACC_ADD: begin
            ps_in[0] = add_x.value;
            ms_in[0] = add_y.value;
            sat_in   = sat_ff | add_x.sat | add_y.sat;
            step_in  = 3'd0;
         end
         ST_ACC_WAIT: begin
            if (mul_rsp.done) begin
               sat_in  = sat_ff | mul_rsp.sat | add_acc.sat;
               step_in = step_ff + 3'd1;
               case (step_ff)
                  3'd0: begin
                     x2_in    = mul_rsp.value;
                     ps_in[1] = add_acc.value;
                  end
                  3'd1: ps_in[2] = add_acc.value;
                  3'd2: ps_in[3] = add_acc.value;
                  3'd3: ms_in[1] = add_acc.value;
                  default: begin
                     ms_in[2] = add_acc.value;
                     count_in = count_ff + COUNT_W'(1);
                  end
               endcase
            end
         end
         ST_FIT_CHECK: begin
            if (few_points) begin
               status_in = STATUS_FEW;
               coef_in   = '{default: '0};
            end
            i_in    = 2'd0;
            j_in    = 2'd0;
            fsat_in = sat_ff;
            perm_in = '{2'd0, 2'd1, 2'd2};
         end
         ST_LOAD: begin
            if (j_ff == 2'd3) begin
               j_in = 2'd0;
               if (i_ff == 2'd2) begin
                  i_in = 2'd0;
                  k_in = 2'd1;
               end else begin
                  i_in = i_ff + 2'd1;
               end
            end else begin
               j_in = j_ff + 2'd1;
            end
         end
         ST_PIV_CMP: begin
            if (swap_rows) begin
               perm_in[i_ff] = perm_ff[k_ff];
               perm_in[k_ff] = perm_ff[i_ff];
            end
            if (k_ff != 2'd2) begin
               k_in = k_ff + 2'd1;
            end
         end
         ST_ZCHK: begin
            if (rd_a_ff == '0) begin
               status_in = STATUS_PIVOT;
               coef_in   = '{default: '0};
            end
            k_in = i_ff + 2'd1;
         end
         ST_ELIM_DIV_WAIT: begin
            if (div_rsp.done) begin
               term_in = div_rsp.value;
               fsat_in = fsat_ff | div_rsp.sat;
               j_in    = i_ff + 2'd1;
            end
         end
         ST_ELIM_MUL: opnd_in = rd_b_ff;
         ST_ELIM_MUL_WAIT: begin
            if (mul_rsp.done) begin
               fsat_in = fsat_ff | mul_rsp.sat | sub_res.sat;
               if (j_ff != 2'd3) begin
                  j_in = j_ff + 2'd1;
               end else if (k_ff != 2'd2) begin
                  k_in = k_ff + 2'd1;
               end else if (i_ff == 2'd1) begin
                  i_in = 2'd2;
               end else begin
                  i_in = 2'd1;
                  k_in = 2'd2;
               end
            end
         end
         ST_BACK_RD: j_in = i_ff + 2'd1;
         ST_BACK_ACC: opnd_in = rd_a_ff;
         ST_BACK_MUL_WAIT: begin
            if (mul_rsp.done) begin
               opnd_in = sub_res.value;
               fsat_in = fsat_ff | mul_rsp.sat | sub_res.sat;
               j_in    = j_ff + 2'd1;
            end
         end
         ST_BACK_DCHK: begin
            if (rd_a_ff == '0) begin
               status_in = STATUS_PIVOT;
               coef_in   = '{default: '0};
            end
         end
         ST_BACK_DIV_WAIT: begin
            if (div_rsp.done) begin
               coef_in[i_ff] = div_rsp.value;
               fsat_in       = fsat_ff | div_rsp.sat;
               if (i_ff != 2'd0) begin
                  i_in = i_ff - 2'd1;
               end
            end
         end
         ST_FINISH: begin
            for (int r = 0; r < 3; r++) begin
               if (coef_ff[r] > COEF_MAX) begin
                  coef_in[r] = COEF_MAX;
               end else if (coef_ff[r] < COEF_MIN) begin
                  coef_in[r] = COEF_MIN;
               end
            end
            if (fsat_ff || (coef_ff[0] > COEF_MAX) || (coef_ff[0] < COEF_MIN) ||
                (coef_ff[1] > COEF_MAX) || (coef_ff[1] < COEF_MIN) ||
                (coef_ff[2] > COEF_MAX) || (coef_ff[2] < COEF_MIN)) begin
               status_in = STATUS_SAT;
            end else begin
               status_in = STATUS_OK;
            end
         end
         ST_OUT: begin
            count_in = '0;
            ps_in    = '{default: '0};
            ms_in    = '{default: '0};
            sat_in   = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ps_ff    <= '{default: '0};
         ms_ff    <= '{default: '0};
         sat_ff   <= 1'b0;
         min_ff   <= MIN_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ps_ff    <= ps_in;
         ms_ff    <= ms_in;
         sat_ff   <= sat_in;
         if (csr_bus.valid && csr_bus.ready) begin
            min_ff <= csr_bus.min_points;
         end
      end
      x_ff      <= x_in;
      y_ff      <= y_in;
      last_ff   <= last_in;
      x2_ff     <= x2_in;
      term_ff   <= term_in;
      opnd_ff   <= opnd_in;
      coef_ff   <= coef_in;
      perm_ff   <= perm_in;
      fsat_ff   <= fsat_in;
      status_ff <= status_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      step_ff   <= step_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mat_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mat_mem[addr_a];
      rd_b_ff <= mat_mem[addr_b];
   end

   assign csr_bus.ready        = 1'b1;
   assign rsp_bus.coeff_const  = coef_ff[0][COEF_W-1:0];
   assign rsp_bus.coeff_linear = coef_ff[1][COEF_W-1:0];
   assign rsp_bus.coeff_square = coef_ff[2][COEF_W-1:0];
   assign rsp_bus.fit_status   = status_ff;

`ifndef SYNTHESIS
   a_no_accept_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !req_bus.ready)
      else $error("point accepted while a result beat is pending");

   a_mul_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == ST_ACC_WAIT || state_ff == ST_ELIM_MUL_WAIT ||
                        state_ff == ST_BACK_MUL_WAIT))
      else $error("multiplier finished outside a wait state");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_ELIM_DIV_WAIT || state_ff == ST_BACK_DIV_WAIT))
      else $error("divider finished outside a wait state");

   a_failed_fit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (status_ff == STATUS_FEW || status_ff == STATUS_PIVOT)) |->
      (coef_ff[0] == '0 && coef_ff[1] == '0 && coef_ff[2] == '0))
      else $error("failed fit carries nonzero coefficients");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_POINTS))
      else $error("point count above its limit");
`endif

endmodule

// ----- design/qlsf_mul.sv -----
// Shared fixed-point multiplier: four 32x32 partial products accumulated in turn, then
// the fraction shift and saturation. Depends on qlsf_pkg.
module qlsf_mul import qlsf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  unit_req_type req,
   output unit_rsp_type rsp
);

   logic [WORD_W-1:0]   a_ff, a_in, b_ff, b_in;
   logic                neg_ff, neg_in;
   logic [2*WORD_W-1:0] prod_ff, prod_in;
   logic [2:0]          step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [WORD_W-1:0]   value_ff, value_in;
   logic                sat_ff, sat_in;

   logic [31:0]         a_part, b_part;
   logic [63:0]         pp;
   logic [2*WORD_W-1:0] pp_wide;
   arith_type           fin;

   always_comb begin
      a_part = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
      b_part = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp     = a_part * b_part;
      case (step_ff[1:0])
         2'd0:    pp_wide = {64'd0, pp};
         2'd3:    pp_wide = {pp, 64'd0};
         default: pp_wide = {32'd0, pp, 32'd0};
      endcase
      fin = sign_apply(neg_ff, prod_ff[FRAC_BITS +: WORD_W],
                       |prod_ff[2*WORD_W-1:FRAC_BITS+WORD_W]);
   end

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      value_in = value_ff;
      sat_in   = sat_ff;
      if (req.start) begin
         a_in    = magnitude(req.a);
         b_in    = magnitude(req.b);
         neg_in  = req.a[WORD_W-1] ^ req.b[WORD_W-1];
         prod_in = '0;
         step_in = 3'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff[2]) begin
            value_in = fin.value;
            sat_in   = fin.sat;
            done_in  = 1'b1;
            busy_in  = 1'b0;
         end else begin
            prod_in = prod_ff + pp_wide;
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      neg_ff   <= neg_in;
      prod_ff  <= prod_in;
      value_ff <= value_in;
      sat_ff   <= sat_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;
   assign rsp.sat   = sat_ff;

endmodule

// ----- design/qlsf_div.sv -----
// Shared fixed-point divider: restoring long division of (|num| << FRAC_BITS) by |den|,
// one quotient bit per cycle, then sign and saturation. Depends on qlsf_pkg.
module qlsf_div import qlsf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  unit_req_type req,
   output unit_rsp_type rsp
);

   logic [WORD_W-1:0]   dm_ff, dm_in;
   logic [2*WORD_W-1:0] dvd_ff, dvd_in;
   logic [WORD_W-1:0]   rem_ff, rem_in;
   logic [WORD_W-1:0]   q_ff, q_in;
   logic                over_ff, over_in;
   logic                neg_ff, neg_in;
   logic [6:0]          cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                fin_ff, fin_in;
   logic                done_ff, done_in;
   logic [WORD_W-1:0]   value_ff, value_in;
   logic                sat_ff, sat_in;

   logic [WORD_W:0]     rem_ext, diff;
   logic                ge;
   arith_type           res;

   always_comb begin
      rem_ext = {rem_ff, dvd_ff[2*WORD_W-1]};
      ge      = rem_ext >= {1'b0, dm_ff};
      diff    = rem_ext - {1'b0, dm_ff};
      res     = sign_apply(neg_ff, q_ff, over_ff);
   end

   always_comb begin
      dm_in    = dm_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      over_in  = over_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      fin_in   = fin_ff;
      done_in  = 1'b0;
      value_in = value_ff;
      sat_in   = sat_ff;
      if (req.start) begin
         dm_in   = magnitude(req.b);
         dvd_in  = {64'd0, magnitude(req.a)} << FRAC_BITS;
         rem_in  = '0;
         q_in    = '0;
         over_in = 1'b0;
         neg_in  = req.a[WORD_W-1] ^ req.b[WORD_W-1];
         cnt_in  = 7'd127;
         busy_in = 1'b1;
         fin_in  = 1'b0;
      end else if (busy_ff) begin
         if (fin_ff) begin
            value_in = res.value;
            sat_in   = res.sat;
            done_in  = 1'b1;
            busy_in  = 1'b0;
            fin_in   = 1'b0;
         end else begin
            rem_in = ge ? diff[WORD_W-1:0] : rem_ext[WORD_W-1:0];
            dvd_in = dvd_ff << 1;
            if (cnt_ff[6]) begin
               over_in = over_ff | ge;
            end else begin
               q_in = {q_ff[WORD_W-2:0], ge};
            end
            cnt_in = cnt_ff - 7'd1;
            fin_in = (cnt_ff == 7'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      dm_ff    <= dm_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      over_ff  <= over_in;
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
      value_ff <= value_in;
      sat_ff   <= sat_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;
   assign rsp.sat   = sat_ff;

endmodule

// ----- tb/sv/tb_qlsf_checker.sv -----
// Checker for the quadratic least-squares fit core: watches the point, result and
// configuration channels, predicts each fit result and compares it field by field.
// Depends on qlsf_pkg and qlsf_if.
module tb_qlsf_checker import qlsf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   qlsf_req_if.sink   req_mon,
   qlsf_rsp_if.sink   rsp_mon,
   qlsf_csr_if.sink   csr_mon,
   output int         error_count,
   output int         pending_fits,
   output int         fits_seen,
   output int         status_seen [4]
);

   typedef struct {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      fit_status_type           status;
   } fit_result_type;

   fit_result_type           expected_fits[$];
   logic [MIN_W-1:0]         min_pts;
   int unsigned              npoints;
   logic signed [63:0]       sx[4];
   logic signed [63:0]       sy[3];
   logic signed [63:0]       mat[3][4];
   bit                       sticky_sat;

   function automatic logic [63:0] abs64(logic signed [63:0] v);
      return v < 0 ? 64'd0 - v : v;
   endfunction

   function automatic logic signed [63:0] signed_clamp(bit neg, logic [63:0] m, bit over,
                                                       ref bit sat);
      if (neg) begin
         if (over || m > 64'h8000_0000_0000_0000) begin
            sat = 1;
            return 64'sh8000_0000_0000_0000;
         end
         return -m;
      end
      if (over || m[63]) begin
         sat = 1;
         return 64'sh7FFF_FFFF_FFFF_FFFF;
      end
      return m;
   endfunction

   function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
                                                  logic signed [63:0] b, ref bit sat);
      logic signed [64:0] s;
      s = a + b;
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
         sat = 1;
         return 64'sh7FFF_FFFF_FFFF_FFFF;
      end
      if (s < -65'sh0_8000_0000_0000_0000) begin
         sat = 1;
         return 64'sh8000_0000_0000_0000;
      end
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sub_sat(logic signed [63:0] a,
                                                  logic signed [63:0] b, ref bit sat);
      logic signed [64:0] s;
      s = a - b;
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
         sat = 1;
         return 64'sh7FFF_FFFF_FFFF_FFFF;
      end
      if (s < -65'sh0_8000_0000_0000_0000) begin
         sat = 1;
         return 64'sh8000_0000_0000_0000;
      end
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] q_mul(logic signed [63:0] a,
                                                logic signed [63:0] b, ref bit sat);
      logic [127:0] p;
      p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
      return signed_clamp((a < 0) != (b < 0), p[FRAC_BITS +: 64],
                          p[127:64+FRAC_BITS] != 0, sat);
   endfunction

   function automatic logic signed [63:0] q_div(logic signed [63:0] num,
                                                logic signed [63:0] den, ref bit sat);
      logic [127:0] q;
      q = ({64'd0, abs64(num)} << FRAC_BITS) / {64'd0, abs64(den)};
      return signed_clamp((num < 0) != (den < 0), q[63:0], q[127:64] != 0, sat);
   endfunction

   function automatic fit_status_type solve_normal(ref logic signed [63:0] c[3],
                                                   ref bit sat);
      logic signed [63:0] t, acc, term;
      for (int i = 0; i < 2; i++) begin
         for (int k = i + 1; k < 3; k++)
            if (abs64(mat[k][i]) > abs64(mat[i][i]))
               for (int j = 0; j < 4; j++) begin
                  t = mat[i][j];
                  mat[i][j] = mat[k][j];
                  mat[k][j] = t;
               end
         if (mat[i][i] == 0) return STATUS_PIVOT;
         for (int k = i + 1; k < 3; k++) begin
            term = q_div(mat[k][i], mat[i][i], sat);
            for (int j = i + 1; j < 4; j++)
               mat[k][j] = sub_sat(mat[k][j], q_mul(term, mat[i][j], sat), sat);
            mat[k][i] = 0;
         end
      end
      for (int i = 2; i >= 0; i--) begin
         acc = mat[i][3];
         for (int j = i + 1; j < 3; j++)
            acc = sub_sat(acc, q_mul(mat[i][j], c[j], sat), sat);
         if (mat[i][i] == 0) return STATUS_PIVOT;
         c[i] = q_div(acc, mat[i][i], sat);
      end
      return STATUS_OK;
   endfunction

   task automatic clear_sums();
      npoints = 0;
      sticky_sat = 0;
      foreach (sx[i]) sx[i] = 0;
      foreach (sy[i]) sy[i] = 0;
   endtask

   task automatic take_point(logic signed [31:0] xi, logic signed [31:0] yi, logic lastp);
      logic signed [63:0] x, y, x2, x3, x4, pw[5], c[3];
      fit_result_type     r;
      bit                 sat;
      x = xi;
      y = yi;
      c = '{0, 0, 0};
      if (npoints < MAX_POINTS) begin
         x2 = q_mul(x, x, sticky_sat);
         x3 = q_mul(x2, x, sticky_sat);
         x4 = q_mul(x2, x2, sticky_sat);
         sx[0] = add_sat(sx[0], x, sticky_sat);
         sx[1] = add_sat(sx[1], x2, sticky_sat);
         sx[2] = add_sat(sx[2], x3, sticky_sat);
         sx[3] = add_sat(sx[3], x4, sticky_sat);
         sy[0] = add_sat(sy[0], y, sticky_sat);
         sy[1] = add_sat(sy[1], q_mul(x, y, sticky_sat), sticky_sat);
         sy[2] = add_sat(sy[2], q_mul(x2, y, sticky_sat), sticky_sat);
         npoints++;
      end
      if (!lastp) return;
      if (npoints < min_pts) begin
         r.status = STATUS_FEW;
      end else begin
         sat = sticky_sat;
         pw[0] = 64'(npoints) << FRAC_BITS;
         for (int i = 0; i < 4; i++) pw[i+1] = sx[i];
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) mat[i][j] = pw[i+j];
            mat[i][3] = sy[i];
         end
         r.status = solve_normal(c, sat);
         if (r.status == STATUS_OK) begin
            for (int i = 0; i < 3; i++) begin
               if (c[i] > COEF_MAX) begin
                  c[i] = COEF_MAX;
                  sat = 1;
               end
               if (c[i] < COEF_MIN) begin
                  c[i] = COEF_MIN;
                  sat = 1;
               end
            end
            if (sat) r.status = STATUS_SAT;
         end else begin
            c = '{0, 0, 0};
         end
      end
      r.b0 = c[0][COEF_W-1:0];
      r.b1 = c[1][COEF_W-1:0];
      r.b2 = c[2][COEF_W-1:0];
      expected_fits.push_back(r);
      clear_sums();
   endtask

   always @(posedge clock) begin
      fit_result_type e;
      if (reset) begin
         min_pts <= MIN_RESET;
         clear_sums();
         expected_fits.delete();
         error_count <= 0;
         fits_seen <= 0;
         foreach (status_seen[i]) status_seen[i] <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) min_pts <= csr_mon.min_points;
         if (req_mon.valid && req_mon.ready)
            take_point(req_mon.x_value, req_mon.y_value, req_mon.last_point);
         if (rsp_mon.valid && rsp_mon.ready) begin
            fits_seen <= fits_seen + 1;
            status_seen[rsp_mon.fit_status] <= status_seen[rsp_mon.fit_status] + 1;
            if (expected_fits.size() == 0) begin
               $display("%0t: unexpected result beat, status %0d", $time,
                        rsp_mon.fit_status);
               error_count <= error_count + 1;
            end else begin
               e = expected_fits.pop_front();
               if (e.b0 !== rsp_mon.coeff_const || e.b1 !== rsp_mon.coeff_linear ||
                   e.b2 !== rsp_mon.coeff_square || e.status !== rsp_mon.fit_status) begin
                  $display("%0t: mismatch expected b0=%h b1=%h b2=%h st=%0d", $time,
                           e.b0, e.b1, e.b2, e.status);
                  $display("%0t:          actual   b0=%h b1=%h b2=%h st=%0d", $time,
                           rsp_mon.coeff_const, rsp_mon.coeff_linear,
                           rsp_mon.coeff_square, rsp_mon.fit_status);
                  error_count <= error_count + 1;
               end
            end
         end
      end
      pending_fits <= expected_fits.size();
   end

endmodule

// ----- tb/sv/tb_quadratic_least_squares_fit_core.sv -----
// Top of the fit core testbench: clock, reset, point and configuration stimulus,
// result-side stalls and the verdict. Depends on qlsf_pkg, qlsf_if, tb_qlsf_checker.
module tb_quadratic_least_squares_fit_core;
   import qlsf_pkg::*;

   logic clock = 0;
   logic reset = 1;
   int   error_count, pending_fits, fits_seen;
   int   status_seen [4];
   int   send_idle_pct = 0, recv_idle_pct = 0;
   bit   hold_off = 0;

   qlsf_req_if req_bus ();
   qlsf_rsp_if rsp_bus ();
   qlsf_csr_if csr_bus ();

   quadratic_least_squares_fit_core dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source), .csr_bus(csr_bus.sink)
   );

   tb_qlsf_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_mon(req_bus.sink), .rsp_mon(rsp_bus.sink), .csr_mon(csr_bus.sink),
      .error_count(error_count), .pending_fits(pending_fits),
      .fits_seen(fits_seen), .status_seen(status_seen)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   initial begin
      #60000000;
      $display("tb_quadratic_least_squares_fit_core: done, errors");
      $finish;
   end

   initial begin
      rsp_bus.ready = 0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, logic lastp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 0;
         @(posedge clock);
      end
      req_bus.valid      <= 1;
      req_bus.x_value    <= x;
      req_bus.y_value    <= y;
      req_bus.last_point <= lastp;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic go_idle();
      req_bus.valid <= 0;
      @(posedge clock);
      while (pending_fits != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   task automatic write_min_points(logic [MIN_W-1:0] v);
      go_idle();
      csr_bus.valid      <= 1;
      csr_bus.min_points <= v;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 0;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord(int kind);
      case (kind)
         0: return $signed($urandom_range(32'h0600_0000)) - 32'sh0300_0000;
         1: return $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
         2: return $urandom;
         default: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      endcase
   endfunction

   task automatic send_set(int n, int kind);
      logic signed [31:0] x;
      for (int i = 0; i < n; i++) begin
         x = ($urandom_range(9) == 0) ? rand_coord(3) : rand_coord(kind);
         if (kind == 0 && $urandom_range(3) == 0) x = $signed(i) <<< 24;
         send_point(x, rand_coord(kind == 3 ? 2 : kind), i == n - 1);
      end
   endtask

   int sent;

   initial begin
      req_bus.valid = 0;
      req_bus.x_value = 0;
      req_bus.y_value = 0;
      req_bus.last_point = 0;
      csr_bus.valid = 0;
      csr_bus.min_points = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: exact parabola, few points, repeated x, extremes, overflowing set.
      for (int i = 0; i < 5; i++)
         send_point($signed(i) <<< 24, (1 + 2 * i + i * i) <<< 24, i == 4);
      send_point(32'sh0100_0000, 32'sh0100_0000, 1);
      for (int i = 0; i < 5; i++) send_point(32'sh0200_0000, 32'sh0300_0000, i == 4);
      send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 0);
      send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 0);
      send_point(32'sh0000_0000, 32'shFFFF_FFFF, 0);
      send_point(32'shFFFF_FFFF, 32'sh0000_0000, 0);
      send_point(32'sh5555_5555, 32'shAAAA_AAAA, 1);
      send_point(0, 0, 1);
      write_min_points(6'd0);
      send_point(0, 0, 1);
      write_min_points(6'd63);
      send_set(40, 0);
      write_min_points(6'd3);
      send_set(3, 0);
      sent = 61;

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = ph == 0 ? 20 : ph == 1 ? 57 : 0;
         recv_idle_pct = ph == 0 ? 57 : ph == 1 ? 20 : 0;
         write_min_points(ph == 0 ? 6'd32 : ph == 1 ? 6'($urandom_range(63)) : 6'd3);
         for (int s = 0; s < 14; s++) begin
            int n, kind;
            n = ($urandom_range(9) == 0) ? $urandom_range(33, 36) : $urandom_range(1, 9);
            kind = $urandom_range(9) < 6 ? 0 : $urandom_range(1, 3);
            if (ph == 2 && s == 3) begin
               hold_off = 1;
               fork
                  begin
                     repeat (3000) @(posedge clock);
                     hold_off = 0;
                  end
               join_none
            end
            send_set(n, kind);
            sent += n;
         end
      end

      go_idle();
      $display("Sent %0d points, %0d fits checked: ok %0d, few %0d, pivot %0d, sat %0d.",
               sent, fits_seen, status_seen[0], status_seen[1], status_seen[2],
               status_seen[3]);
      if (error_count == 0)
         $display("tb_quadratic_least_squares_fit_core: done, clean");
      else
         $display("tb_quadratic_least_squares_fit_core: done, errors");
      $finish;
   end

endmodule
